FILE: src/skf_pkg.sv
// Shared constants and types of the six-channel scalar Kalman filter.
`default_nettype none
package skf_pkg;

	localparam int CHANNELS = 6;
	localparam int CH_W = 3;
	localparam int MEAS_W = 24;
	localparam int MEAS_FRAC = 8;
	localparam int EST_W = 32;
	localparam int VAR_W = 32;
	localparam int GAIN_W = 17;
	localparam int FRAC_G = 16;
	localparam int CFG_W = 16;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_INIT_VAR = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NOISE = 1'd1;

	localparam logic [CFG_W-1:0] INIT_VAR_RST = 16'd255;
	localparam logic [CFG_W-1:0] NOISE_RST = 16'd25;

	localparam logic REQ_SAMPLE = 1'b0;
	localparam logic REQ_REBASE = 1'b1;

	typedef struct packed {
		logic                    start;
		logic [VAR_W-1:0]        variance;
		logic [VAR_W:0]          den;
		logic signed [EST_W:0]   diff;
	} skf_eng_req_t;

	typedef struct packed {
		logic                    done;
		logic [GAIN_W-1:0]       gain;
		logic signed [EST_W-1:0] delta;
		logic [VAR_W-1:0]        var_new;
	} skf_eng_rsp_t;

endpackage
`default_nettype wire

FILE: src/skf_req_if.sv
// Request channel of the filter: request type, channel and measurement.
`default_nettype none
interface skf_req_if
	import skf_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic                     req_type;
	logic [CH_W-1:0]          channel;
	logic signed [MEAS_W-1:0] measurement;

	modport source (output valid, output req_type, output channel, output measurement,
		input ready);
	modport sink (input valid, input req_type, input channel, input measurement,
		output ready);
endinterface
`default_nettype wire

FILE: src/skf_rsp_if.sv
// Result channel of the filter: channel, estimate and gain.
`default_nettype none
interface skf_rsp_if
	import skf_pkg::*;
();
	logic                    valid;
	logic                    ready;
	logic [CH_W-1:0]         out_channel;
	logic signed [EST_W-1:0] estimate_out;
	logic [GAIN_W-1:0]       gain_out;

	modport source (output valid, output out_channel, output estimate_out, output gain_out,
		input ready);
	modport sink (input valid, input out_channel, input estimate_out, input gain_out,
		output ready);
endinterface
`default_nettype wire

FILE: src/skf_engine.sv
// Bit-serial gain divider with serial estimate and variance products.
`default_nettype none
module skf_engine
	import skf_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  skf_eng_req_t ctl,
	output skf_eng_rsp_t stat
);
	localparam int REM_W = VAR_W + 1;
	localparam int ACC_E_W = EST_W + GAIN_W + 2;
	localparam int ACC_V_W = VAR_W + GAIN_W;
	localparam int CNT_W = $clog2(GAIN_W);
	localparam logic [CNT_W-1:0] CNT_FIRST = CNT_W'(GAIN_W - 1);
	localparam logic [ACC_V_W-1:0] ROUND_UP = ACC_V_W'((1 << FRAC_G) - 1);

	logic                      busy_q;
	logic                      done_q;
	logic [CNT_W-1:0]          cnt_q;
	logic                      lsb_q;
	logic                      den_zero_q;
	logic [REM_W-1:0]          rem_q;
	logic [REM_W-1:0]          den_q;
	logic signed [EST_W:0]     diff_q;
	logic [VAR_W-1:0]          var_q;
	logic [GAIN_W-1:0]         gain_q;
	logic signed [ACC_E_W-1:0] acc_e_q;
	logic [ACC_V_W-1:0]        acc_v_q;

	logic [REM_W:0]            shifted;
	logic                      qbit;
	logic [REM_W-1:0]          rem_next;
	logic signed [ACC_E_W-1:0] acc_e_next;
	logic [ACC_V_W-1:0]        acc_v_next;
	logic signed [ACC_E_W-1:0] delta_full;
	logic [ACC_V_W-1:0]        ceil_v;

	// One quotient bit per cycle, most significant first; each bit also steers
	// the two shift-and-add products so they finish together with the gain.
	always_comb begin
		shifted = {rem_q, (cnt_q == CNT_FIRST) ? lsb_q : 1'b0};
		qbit = (shifted >= {1'b0, den_q}) && !den_zero_q;
		rem_next = qbit ? REM_W'(shifted - {1'b0, den_q}) : REM_W'(shifted);
		acc_e_next = (acc_e_q <<< 1) + (qbit ? ACC_E_W'(diff_q) : ACC_E_W'(0));
		acc_v_next = (acc_v_q << 1) + (qbit ? ACC_V_W'(var_q) : ACC_V_W'(0));
		delta_full = acc_e_q >>> FRAC_G;
		ceil_v = (acc_v_q + ROUND_UP) >> FRAC_G;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (ctl.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q <= CNT_FIRST;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q <= REM_W'(ctl.variance >> 1);
			lsb_q <= ctl.variance[0];
			den_q <= ctl.den;
			den_zero_q <= (ctl.den == '0);
			diff_q <= ctl.diff;
			var_q <= ctl.variance;
			gain_q <= '0;
			acc_e_q <= '0;
			acc_v_q <= '0;
		end else if (busy_q) begin
			rem_q <= rem_next;
			gain_q <= {gain_q[GAIN_W-2:0], qbit};
			acc_e_q <= acc_e_next;
			acc_v_q <= acc_v_next;
		end
	end

	assign stat.done = done_q;
	assign stat.gain = gain_q;
	assign stat.delta = delta_full[EST_W-1:0];
	assign stat.var_new = var_q - ceil_v[VAR_W-1:0];
endmodule
`default_nettype wire

FILE: src/scalar_kalman_filter_six_channel_top.sv
// Six-channel scalar Kalman filter: channel state, control and result register.
// A sample request loads the bit-serial gain divider at acceptance; when the divider is done,
// the new estimate and variance are stored, and then the result register loads.
// A rebase request stores its channel state at acceptance; the result register loads after that.
// One request is in work at a time; ready returns as the result register loads, once rsp has room.
// Reset clears all estimates and variances and sets the registers to 255 and 25.
`default_nettype none
module scalar_kalman_filter_six_channel_top
	import skf_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	skf_req_if.sink              req,
	skf_rsp_if.source            rsp,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata
);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN = 2'd1;
	localparam logic [1:0] ST_OUT = 2'd2;
	localparam logic [CH_W:0] CH_LIMIT = (CH_W + 1)'(CHANNELS);

	logic [1:0]              state_q;
	logic [EST_W-1:0]        est_store_q [CHANNELS];
	logic [VAR_W-1:0]        var_store_q [CHANNELS];
	logic [CFG_W-1:0]        init_var_q;
	logic [CFG_W-1:0]        noise_q;
	logic [CH_W-1:0]         ch_q;
	logic [EST_W-1:0]        est_q;
	logic [EST_W-1:0]        res_est_q;
	logic [GAIN_W-1:0]       res_gain_q;
	logic                    out_valid_q;
	logic [CH_W-1:0]         out_ch_q;
	logic [EST_W-1:0]        out_est_q;
	logic [GAIN_W-1:0]       out_gain_q;

	logic                    in_acc;
	logic                    ch_ok;
	logic [EST_W-1:0]        meas_q8;
	logic [EST_W-1:0]        est_rd;
	logic [VAR_W-1:0]        var_rd;
	logic [EST_W-1:0]        est_new;
	logic                    slot_free;
	skf_eng_req_t            eng_ctl;
	skf_eng_rsp_t            eng_stat;

	assign req.ready = (state_q == ST_IDLE);
	assign in_acc = req.valid && req.ready;
	assign ch_ok = ({1'b0, req.channel} < CH_LIMIT);
	assign meas_q8 = {req.measurement, {MEAS_FRAC{1'b0}}};
	assign est_rd = est_store_q[req.channel];
	assign var_rd = var_store_q[req.channel];
	assign est_new = est_q + eng_stat.delta;
	assign slot_free = !out_valid_q || rsp.ready;

	always_comb begin
		eng_ctl.start = in_acc && ch_ok && (req.req_type == REQ_SAMPLE);
		eng_ctl.variance = var_rd;
		eng_ctl.den = {1'b0, var_rd} + {1'b0, noise_q, {FRAC_G{1'b0}}};
		eng_ctl.diff = {meas_q8[EST_W-1], meas_q8} - {est_rd[EST_W-1], est_rd};
	end

	skf_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (eng_ctl),
		.stat   (eng_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_var_q <= INIT_VAR_RST;
			noise_q <= NOISE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_INIT_VAR: init_var_q <= cfg_wdata;
				REG_NOISE: noise_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			for (int i = 0; i < CHANNELS; i++) begin
				est_store_q[i] <= '0;
				var_store_q[i] <= '0;
			end
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && ch_ok) begin
						if (req.req_type == REQ_REBASE) begin
							est_store_q[req.channel] <= meas_q8;
							var_store_q[req.channel] <= {init_var_q, {FRAC_G{1'b0}}};
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_RUN;
						end
					end
				end
				ST_RUN: begin
					if (eng_stat.done) begin
						est_store_q[ch_q] <= est_new;
						var_store_q[ch_q] <= eng_stat.var_new;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			ch_q <= req.channel;
			est_q <= est_rd;
			res_est_q <= meas_q8;
			res_gain_q <= '0;
		end else if (state_q == ST_RUN && eng_stat.done) begin
			res_est_q <= est_new;
			res_gain_q <= eng_stat.gain;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_OUT && slot_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && slot_free) begin
			out_ch_q <= ch_q;
			out_est_q <= res_est_q;
			out_gain_q <= res_gain_q;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.out_channel = out_ch_q;
	assign rsp.estimate_out = out_est_q;
	assign rsp.gain_out = out_gain_q;
endmodule
`default_nettype wire

FILE: src/skf_checker.sv
// Port-level checker of the filter and its binding to the top level.
`default_nettype none
module skf_checker
	import skf_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic [CH_W-1:0]   in_channel,
	input logic              out_valid,
	input logic              out_ready,
	input logic [CH_W-1:0]   out_channel,
	input logic [GAIN_W-1:0] gain_out
);
	localparam logic [CH_W:0] CH_LIMIT = (CH_W + 1)'(CHANNELS);
	localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1 << FRAC_G);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn while stalled");

	a_out_channel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ({1'b0, out_channel} < CH_LIMIT))
		else $error("result for a channel that does not exist");

	a_gain_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (gain_out <= GAIN_ONE))
		else $error("gain above one");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && ({1'b0, in_channel} < CH_LIMIT) |=> !in_ready)
		else $error("new request taken while one is in work");
endmodule

bind scalar_kalman_filter_six_channel_top skf_checker u_skf_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (req.valid),
	.in_ready    (req.ready),
	.in_channel  (req.channel),
	.out_valid   (rsp.valid),
	.out_ready   (rsp.ready),
	.out_channel (rsp.out_channel),
	.gain_out    (rsp.gain_out)
);
`default_nettype wire
